// ===== hw/rtl/lz77x_pkg.sv =====
package lz77x_pkg;

    localparam int WINDOW_DEPTH = 32768;
    localparam int WIN_W        = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = WIN_W + 1;
    localparam int MIN_MATCH    = 3;
    localparam int REM_W        = 5;

    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_MATCH   = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    typedef struct packed {
        logic [7:0]  data;
        logic [31:0] count;
        logic        last;
    } out_item_t;

endpackage

// ===== hw/rtl/lz77x_ram.sv =====
module lz77x_ram #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/lz77_window_token_expander_core.sv =====
// Expands literal, match and end tokens into a byte stream over a 32 KiB history
// window held in one single-port-read, single-port-write RAM. Bytes leave at one
// per cycle while the output is not stalled. A literal token is taken and then
// emits its byte; a match of n bytes (3 to 18) is taken and then issues one window
// read per byte (a copy at distance one is forwarded from the byte being written).
// No new token is taken until the current one is done. A token that finds the
// output limit already reached emits nothing. End tokens and tokens after the end
// are accepted without making the block busy. No clearing pass follows reset:
// a fill count marks which window entries were written, and unwritten ones read as
// zero. The output is buffered two deep, so a stalled consumer pauses the copy loop
// without losing bytes. cfg_we writes output_limit; write it only while idle.
module lz77_window_token_expander_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  token_kind,
    input  logic [7:0]  literal_byte,
    input  logic [14:0] distance,
    input  logic [3:0]  length_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [31:0] byte_count,
    output logic        last
);

    import lz77x_pkg::*;

    logic [31:0]       limit_reg;
    logic              ended_reg;
    logic              busy_reg;
    logic              t_lit_reg;
    logic [7:0]        t_byte_reg;
    logic [WIN_W-1:0]  t_dist_reg;
    logic [REM_W-1:0]  t_rem_reg;

    logic [WIN_W-1:0]  wp_reg;
    logic [31:0]       cnt_reg;
    logic [FILL_W-1:0] fill_reg;

    logic              pend_reg;
    logic              p_lit_reg;
    logic [7:0]        p_byte_reg;
    logic              p_fwd_reg;
    logic [7:0]        p_fwd_byte_reg;
    logic              p_valid_reg;
    logic              p_last_reg;

    out_item_t         ent_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        occ_reg;

    logic              accept;
    logic              start;
    logic [WIN_W-1:0]  wp_eff;
    logic [31:0]       cnt_eff;
    logic [FILL_W-1:0] fill_eff;
    logic [WIN_W-1:0]  rd_addr;
    logic              allowed;
    logic              next_fits;
    logic              is_last;
    logic              room;
    logic              do_issue;
    logic              pop;
    logic [2:0]        occ_after;
    logic [7:0]        mem_q;
    logic [7:0]        byte_comb;
    out_item_t         push_item;

    assign in_ready  = !busy_reg;
    assign accept    = in_valid && in_ready;
    assign start     = accept && !ended_reg
                       && (token_kind == KIND_LITERAL || token_kind == KIND_MATCH);

    assign wp_eff    = wp_reg + {{(WIN_W-1){1'b0}}, pend_reg};
    assign cnt_eff   = cnt_reg + {31'b0, pend_reg};
    assign fill_eff  = (fill_reg == FILL_W'(WINDOW_DEPTH)) ? fill_reg
                       : fill_reg + {{(FILL_W-1){1'b0}}, pend_reg};
    assign rd_addr   = wp_eff - t_dist_reg;

    assign allowed   = cnt_eff < limit_reg;
    assign next_fits = ({1'b0, cnt_eff} + 33'd1) < {1'b0, limit_reg};
    assign is_last   = (t_rem_reg == REM_W'(1)) || !next_fits;

    assign out_valid = (occ_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign occ_after = {1'b0, occ_reg} + {2'b0, pend_reg} - {2'b0, pop};
    assign room      = (occ_after <= 3'd1);
    assign do_issue  = busy_reg && allowed && room;

    assign byte_comb = p_lit_reg   ? p_byte_reg
                     : p_fwd_reg   ? p_fwd_byte_reg
                     : p_valid_reg ? mem_q
                     : 8'd0;

    assign push_item.data  = byte_comb;
    assign push_item.count = cnt_reg + 32'd1;
    assign push_item.last  = p_last_reg;

    assign out_byte   = ent_reg[rd_ptr_reg].data;
    assign byte_count = ent_reg[rd_ptr_reg].count;
    assign last       = ent_reg[rd_ptr_reg].last;

    lz77x_ram #(
        .ADDR_W (WIN_W),
        .DATA_W (8)
    ) u_window (
        .clk   (clk),
        .we    (pend_reg),
        .waddr (wp_reg),
        .wdata (byte_comb),
        .raddr (rd_addr),
        .rdata (mem_q)
    );

    // token sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 32'd0;
            ended_reg <= 1'b0;
            busy_reg  <= 1'b0;
            t_rem_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (accept && !ended_reg && token_kind == KIND_END)
            begin
                ended_reg <= 1'b1;
            end
            if (start)
            begin
                busy_reg <= 1'b1;
                if (token_kind == KIND_LITERAL)
                begin
                    t_rem_reg <= REM_W'(1);
                end
                else
                begin
                    t_rem_reg <= REM_W'(length_code) + REM_W'(MIN_MATCH);
                end
            end
            else if (busy_reg && !allowed)
            begin
                busy_reg <= 1'b0;
            end
            else if (do_issue)
            begin
                t_rem_reg <= t_rem_reg - REM_W'(1);
                if (is_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            t_lit_reg  <= (token_kind == KIND_LITERAL);
            t_byte_reg <= literal_byte;
            t_dist_reg <= distance;
        end
        if (do_issue)
        begin
            p_lit_reg      <= t_lit_reg;
            p_byte_reg     <= t_byte_reg;
            p_fwd_reg      <= pend_reg && (rd_addr == wp_reg);
            p_fwd_byte_reg <= byte_comb;
            p_valid_reg    <= {1'b0, rd_addr} < fill_eff;
            p_last_reg     <= is_last;
        end
    end

    // commit: write the window, advance pointer and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            wp_reg   <= '0;
            cnt_reg  <= 32'd0;
            fill_reg <= '0;
        end
        else
        begin
            pend_reg <= do_issue;
            if (pend_reg)
            begin
                wp_reg   <= wp_reg + WIN_W'(1);
                cnt_reg  <= cnt_reg + 32'd1;
                fill_reg <= fill_eff;
            end
        end
    end

    // output buffer, two deep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            occ_reg    <= 2'd0;
        end
        else
        begin
            if (pend_reg)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            occ_reg <= occ_after[1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            ent_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
